FILE: sv/dle_pkg.sv
package dle_pkg;

  localparam int DataW   = 16;
  localparam int RowsMax = 64;
  localparam int ColsMax = 64;
  localparam int AddrW   = 12;
  localparam int DimW    = 7;
  localparam int VecW    = 6;
  localparam int ProdW   = 2 * DataW;
  localparam int AccW    = 40;
  localparam int WDepth  = RowsMax * ColsMax;
  localparam int CfgIdxW = 2;

  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_ADD   = 3'd1,
    OP_FWD   = 3'd2,
    OP_BWD   = 3'd3,
    OP_OUTER = 3'd4
  } op_e;

  localparam logic [CfgIdxW-1:0] CFG_ROWS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_COLS = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_ADD  = 3'b010,
    ST_RUN  = 3'b100
  } state_e;

  typedef enum logic [1:0] {
    MODE_FWD   = 2'd0,
    MODE_BWD   = 2'd1,
    MODE_OUTER = 2'd2
  } mode_e;

  // per-term tag that rides along the multiply-accumulate pipeline
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             term_last;
    logic             res_last;
    logic [AddrW-1:0] res_idx;
    logic             use_g;
    logic             use_grad;
  } tag_t;

  typedef struct packed {
    tag_t             tag;
    logic [AddrW-1:0] waddr;
    logic [VecW-1:0]  vaddr;
  } iss_t;

  typedef struct packed {
    logic w_wr;
    logic in_wr;
    logic grad_wr;
    logic add_wr;
  } ctl_t;

endpackage

FILE: sv/dense_layer_engine_core.sv
// Weight write: the block stays ready. Weight add: busy while the sum is written back.
// Forward run: rows*cols products on the shared multiplier, then the pipeline; the
// first word follows the closing element once the cols products of its row are summed.
// Backward run: cols*rows products likewise; outer row: cols products, one word each.
// The receiver cannot stall: each word is on the result ports for one cycle.
// rst_ni clears control and sets both dimensions to 64; stores are not cleared.
module dense_layer_engine_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        opcode_i,
  input  logic [dle_pkg::AddrW-1:0]         index_i,
  input  logic signed [dle_pkg::DataW-1:0]  value_i,
  output logic                              result_valid_o,
  output logic signed [dle_pkg::AccW-1:0]   result_o,
  output logic [dle_pkg::AddrW-1:0]         result_index_o,
  output logic                              last_o,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dle_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [dle_pkg::DimW-1:0]          cfg_data_i
);
  import dle_pkg::*;

  logic [DimW-1:0]         rows_cfg_q, cols_cfg_q;
  logic [DimW-1:0]         rows, cols;
  logic                    accept;
  logic                    seq_busy, mac_busy;
  ctl_t                    ctl;
  iss_t                    iss;
  logic [AddrW-1:0]        idx_q;
  logic signed [DataW-1:0] val_q;

  logic [DataW-1:0]        w_mem [WDepth];
  logic [DataW-1:0]        in_mem [ColsMax];
  logic [DataW-1:0]        grad_mem [RowsMax];
  logic [DataW-1:0]        w_rdata_q, in_rdata_q, grad_rdata_q;
  logic [AddrW-1:0]        w_raddr, w_waddr;
  logic [DataW-1:0]        w_wdata;
  logic                    w_we;
  logic signed [DataW:0]   add_sum;
  logic [DataW-1:0]        add_sat;
  tag_t                    tag_q;
  logic signed [DataW-1:0] mac_a, mac_b;
  logic [AccW-1:0]         mac_res;

  assign busy      = seq_busy | tag_q.valid | mac_busy;
  assign accept    = start & ~busy;
  assign cfg_ready = ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= DimW'(RowsMax);
      cols_cfg_q <= DimW'(ColsMax);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index_i == CFG_ROWS) rows_cfg_q <= cfg_data_i;
      if (cfg_index_i == CFG_COLS) cols_cfg_q <= cfg_data_i;
    end
  end

  // zero acts as one, anything past the array size acts as the size
  always_comb begin
    rows = rows_cfg_q;
    cols = cols_cfg_q;
    if (rows_cfg_q == '0) rows = DimW'(1);
    else if (rows_cfg_q > DimW'(RowsMax)) rows = DimW'(RowsMax);
    if (cols_cfg_q == '0) cols = DimW'(1);
    else if (cols_cfg_q > DimW'(ColsMax)) cols = DimW'(ColsMax);
  end

  dle_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .opcode_i (opcode_i),
    .index_i  (index_i),
    .rows_i   (rows),
    .cols_i   (cols),
    .ctl_o    (ctl),
    .iss_o    (iss),
    .busy_o   (seq_busy)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q <= index_i;
      val_q <= value_i;
    end
  end

  assign add_sum = {w_rdata_q[DataW-1], w_rdata_q} + {val_q[DataW-1], val_q};
  always_comb begin
    add_sat = add_sum[DataW-1:0];
    if (add_sum[DataW] != add_sum[DataW-1]) begin
      add_sat = add_sum[DataW] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end
  end

  assign w_raddr = seq_busy ? iss.waddr : index_i;
  assign w_we    = ctl.w_wr | ctl.add_wr;
  assign w_waddr = ctl.add_wr ? idx_q : index_i;
  assign w_wdata = ctl.add_wr ? add_sat : value_i;

  always_ff @(posedge clk_i) begin
    if (w_we) w_mem[w_waddr] <= w_wdata;
    w_rdata_q <= w_mem[w_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ctl.in_wr) in_mem[index_i[VecW-1:0]] <= value_i;
    in_rdata_q <= in_mem[iss.vaddr];
  end

  always_ff @(posedge clk_i) begin
    if (ctl.grad_wr) grad_mem[index_i[VecW-1:0]] <= value_i;
    grad_rdata_q <= grad_mem[iss.vaddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= iss.tag;
    end
  end

  assign mac_a = tag_q.use_g ? val_q : w_rdata_q;
  assign mac_b = tag_q.use_grad ? grad_rdata_q : in_rdata_q;

  dle_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tag_i       (tag_q),
    .a_i         (mac_a),
    .b_i         (mac_b),
    .busy_o      (mac_busy),
    .res_valid_o (result_valid_o),
    .result_o    (mac_res),
    .res_idx_o   (result_index_o),
    .last_o      (last_o)
  );

  assign result_o = mac_res;

endmodule

FILE: sv/dle_mac.sv
module dle_mac (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dle_pkg::tag_t                tag_i,
  input  logic signed [dle_pkg::DataW-1:0] a_i,
  input  logic signed [dle_pkg::DataW-1:0] b_i,
  output logic                         busy_o,
  output logic                         res_valid_o,
  output logic [dle_pkg::AccW-1:0]     result_o,
  output logic [dle_pkg::AddrW-1:0]    res_idx_o,
  output logic                         last_o
);
  import dle_pkg::*;

  tag_t                    tag_q;
  logic signed [ProdW-1:0] p_q;
  logic [AccW-1:0]         acc_q;
  logic [AccW-1:0]         sum_d;
  logic                    res_valid_q;
  logic [AccW-1:0]         result_q;
  logic [AddrW-1:0]        res_idx_q;
  logic                    last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      tag_q       <= tag_i;
      res_valid_q <= tag_q.valid & tag_q.term_last;
    end
  end

  assign sum_d = (tag_q.first ? '0 : acc_q) + AccW'(p_q);

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
    if (tag_q.valid) begin
      acc_q <= sum_d;
    end
    if (tag_q.valid & tag_q.term_last) begin
      result_q  <= sum_d;
      res_idx_q <= tag_q.res_idx;
      last_q    <= tag_q.res_last;
    end
  end

  assign busy_o      = tag_q.valid;
  assign res_valid_o = res_valid_q;
  assign result_o    = result_q;
  assign res_idx_o   = res_idx_q;
  assign last_o      = last_q;

endmodule

FILE: sv/dle_seq.sv
module dle_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [2:0]                  opcode_i,
  input  logic [dle_pkg::AddrW-1:0]   index_i,
  input  logic [dle_pkg::DimW-1:0]    rows_i,
  input  logic [dle_pkg::DimW-1:0]    cols_i,
  output dle_pkg::ctl_t               ctl_o,
  output dle_pkg::iss_t               iss_o,
  output logic                        busy_o
);
  import dle_pkg::*;

  state_e           state_q, state_d;
  mode_e            mode_q, mode_d;
  logic [VecW-1:0]  outer_q, outer_d;
  logic [VecW-1:0]  inner_q, inner_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic             start;
  mode_e            start_mode;
  logic             in_cols, in_rows;
  logic [DimW-1:0]  n_inner, n_outer;
  logic             inner_end, outer_end;
  logic [AddrW:0]   outer_base;
  op_e              op;

  assign op      = op_e'(opcode_i);
  assign in_cols = index_i < AddrW'(cols_i);
  assign in_rows = index_i < AddrW'(rows_i);
  assign outer_base = (AddrW+1)'(index_i[VecW-1:0]) * (AddrW+1)'(cols_i);

  always_comb begin
    ctl_o      = '0;
    start      = 1'b0;
    start_mode = MODE_FWD;
    if (accept_i) begin
      case (op)
        OP_WRITE: ctl_o.w_wr = 1'b1;
        OP_ADD:   ;
        OP_FWD: begin
          if (in_cols) begin
            ctl_o.in_wr = 1'b1;
            start       = index_i == AddrW'(cols_i - 1'b1);
          end
        end
        OP_BWD: begin
          if (in_rows) begin
            ctl_o.grad_wr = 1'b1;
            start         = index_i == AddrW'(rows_i - 1'b1);
            start_mode    = MODE_BWD;
          end
        end
        OP_OUTER: begin
          start      = in_rows;
          start_mode = MODE_OUTER;
        end
        default: ;
      endcase
    end
    ctl_o.add_wr = state_q == ST_ADD;
  end

  always_comb begin
    case (mode_q)
      MODE_FWD: begin
        n_inner = cols_i;
        n_outer = rows_i;
      end
      MODE_BWD: begin
        n_inner = rows_i;
        n_outer = cols_i;
      end
      default: begin
        n_inner = cols_i;
        n_outer = DimW'(1);
      end
    endcase
  end

  assign inner_end = {1'b0, inner_q} == n_inner - 1'b1;
  assign outer_end = {1'b0, outer_q} == n_outer - 1'b1;

  always_comb begin
    iss_o                = '0;
    iss_o.tag.valid      = state_q == ST_RUN;
    iss_o.tag.first      = (mode_q == MODE_OUTER) | (inner_q == '0);
    iss_o.tag.term_last  = (mode_q == MODE_OUTER) | inner_end;
    iss_o.tag.res_last   = (mode_q == MODE_OUTER) ? inner_end : outer_end;
    iss_o.tag.res_idx    = (mode_q == MODE_OUTER) ? addr_q : AddrW'(outer_q);
    iss_o.tag.use_g      = mode_q == MODE_OUTER;
    iss_o.tag.use_grad   = mode_q == MODE_BWD;
    iss_o.waddr          = addr_q;
    iss_o.vaddr          = inner_q;
  end

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    outer_d = outer_q;
    inner_d = inner_q;
    addr_d  = addr_q;
    case (state_q)
      ST_IDLE: begin
        if (accept_i && op == OP_ADD) begin
          state_d = ST_ADD;
        end else if (start) begin
          state_d = ST_RUN;
          mode_d  = start_mode;
          outer_d = '0;
          inner_d = '0;
          addr_d  = (start_mode == MODE_OUTER) ? outer_base[AddrW-1:0] : '0;
        end
      end
      ST_ADD: state_d = ST_IDLE;
      ST_RUN: begin
        if (inner_end) begin
          inner_d = '0;
          if (outer_end) begin
            state_d = ST_IDLE;
          end else begin
            outer_d = outer_q + 1'b1;
          end
          // transposed walk restarts at the top of the next column
          addr_d = (mode_q == MODE_BWD) ? AddrW'(outer_q) + 1'b1 : addr_q + 1'b1;
        end else begin
          inner_d = inner_q + 1'b1;
          addr_d  = (mode_q == MODE_BWD) ? addr_q + AddrW'(cols_i) : addr_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q  <= MODE_FWD;
      outer_q <= '0;
      inner_q <= '0;
      addr_q  <= '0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      outer_q <= outer_d;
      inner_q <= inner_d;
      addr_q  <= addr_d;
    end
  end

  assign busy_o = state_q != ST_IDLE;

endmodule

FILE: sv/dle_checker.sv
module dle_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic [2:0]                  opcode_i,
  input logic                        result_valid_o,
  input logic                        cfg_ready
);
  import dle_pkg::*;

  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready == !busy)
    else $error("config port ready while busy");

  a_write_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && opcode_i == OP_WRITE) |=> !busy)
    else $error("weight write held the block");

  a_add_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && opcode_i == OP_ADD) |=> busy)
    else $error("weight add did not take a cycle");

  a_word_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result word without work");

endmodule

bind dense_layer_engine_core dle_checker u_dle_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .opcode_i       (opcode_i),
  .result_valid_o (result_valid_o),
  .cfg_ready      (cfg_ready)
);

FILE: tb/dense_layer_engine_core_test.sv
module dense_layer_engine_core_test;
  import dle_pkg::*;

  localparam int Limit = 1500000;

  typedef struct packed {
    logic [2:0]       op;
    logic [AddrW-1:0] idx;
    logic [DataW-1:0] val;
  } cmd_t;

  typedef struct packed {
    logic [AccW-1:0]  res;
    logic [AddrW-1:0] idx;
    logic             last;
  } word_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [2:0]               opcode_i = '0;
  logic [AddrW-1:0]         index_i = '0;
  logic signed [DataW-1:0]  value_i = '0;
  logic                     result_valid_o;
  logic signed [AccW-1:0]   result_o;
  logic [AddrW-1:0]         result_index_o;
  logic                     last_o;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CfgIdxW-1:0]       cfg_index_i = '0;
  logic [DimW-1:0]          cfg_data_i = '0;

  dense_layer_engine_core dut (
    .clk_i, .rst_ni, .start, .busy, .opcode_i, .index_i, .value_i,
    .result_valid_o, .result_o, .result_index_o, .last_o,
    .cfg_valid, .cfg_ready, .cfg_index_i, .cfg_data_i
  );

  cmd_t  cmd_q[$];
  word_t result_q[$];

  // predictor state
  logic signed [DataW-1:0] weight_mem [WDepth];
  logic signed [DataW-1:0] in_vec [ColsMax];
  logic signed [DataW-1:0] grad_vec [RowsMax];
  logic [DimW-1:0]         rows_reg = 7'd64;
  logic [DimW-1:0]         cols_reg = 7'd64;

  // stimulus side bookkeeping, so no unwritten entry is ever read
  bit in_ok [ColsMax];
  bit grad_ok [RowsMax];
  int gen_rows = 64;
  int gen_cols = 64;

  int  errors = 0;
  int  cycles = 0;
  bit  took = 1'b0;
  int  gap_cnt = 0;
  int  burst_cnt = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int eff_dim(logic [DimW-1:0] d, int lim);
    if (d == 0) return 1;
    if (d > lim) return lim;
    return int'(d);
  endfunction

  function automatic logic signed [DataW-1:0] sat_add(logic signed [DataW-1:0] a,
                                                      logic signed [DataW-1:0] b);
    logic signed [DataW:0] s;
    s = a + b;
    if (s > 32767) return 16'sh7fff;
    if (s < -32768) return 16'sh8000;
    return s[DataW-1:0];
  endfunction

  task automatic predict_layer(cmd_t c);
    int rows, cols;
    logic signed [AccW-1:0] acc;
    word_t w;
    rows = eff_dim(rows_reg, RowsMax);
    cols = eff_dim(cols_reg, ColsMax);
    case (c.op)
      OP_WRITE: weight_mem[c.idx] = c.val;
      OP_ADD:   weight_mem[c.idx] = sat_add(weight_mem[c.idx], c.val);
      OP_FWD: begin
        if (c.idx < cols) begin
          in_vec[c.idx] = c.val;
          if (c.idx == cols - 1) begin
            for (int r = 0; r < rows; r++) begin
              acc = '0;
              for (int k = 0; k < cols; k++) acc += weight_mem[r * cols + k] * in_vec[k];
              w.res = acc; w.idx = AddrW'(r); w.last = (r == rows - 1);
              result_q.push_back(w);
            end
          end
        end
      end
      OP_BWD: begin
        if (c.idx < rows) begin
          grad_vec[c.idx] = c.val;
          if (c.idx == rows - 1) begin
            for (int k = 0; k < cols; k++) begin
              acc = '0;
              for (int r = 0; r < rows; r++) acc += weight_mem[r * cols + k] * grad_vec[r];
              w.res = acc; w.idx = AddrW'(k); w.last = (k == cols - 1);
              result_q.push_back(w);
            end
          end
        end
      end
      OP_OUTER: begin
        if (c.idx < rows) begin
          for (int k = 0; k < cols; k++) begin
            acc = $signed(c.val) * in_vec[k];
            w.res = acc; w.idx = AddrW'(c.idx * cols + k); w.last = (k == cols - 1);
            result_q.push_back(w);
          end
        end
      end
      default: ;
    endcase
  endtask

  // result check, then prediction for a word accepted at this edge
  always @(posedge clk_i) begin
    word_t e;
    cycles <= cycles + 1;
    took <= start && !busy;
    if (rst_ni && result_valid_o) begin
      if (result_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: res %h idx %0d last %b",
                                   result_o, result_index_o, last_o);
      end else begin
        e = result_q.pop_front();
        if (e.res !== result_o || e.idx !== result_index_o || e.last !== last_o) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp res %h idx %0d last %b, got res %h idx %0d last %b",
                     e.res, e.idx, e.last, result_o, result_index_o, last_o);
        end
      end
    end
    if (rst_ni && start && !busy) predict_layer('{opcode_i, index_i, value_i});
  end

  always @(posedge clk_i) begin
    if (cycles > Limit) begin
      $display("dense_layer_engine_core test failed");
      $finish;
    end
  end

  // driver: bursts of words with random gaps
  always @(negedge clk_i) begin
    cmd_t c;
    if (!(start && !took) && rst_ni) begin
      if (gap_cnt > 0) begin
        gap_cnt <= gap_cnt - 1;
        start <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        c = cmd_q.pop_front();
        opcode_i <= c.op;
        index_i <= c.idx;
        value_i <= c.val;
        start <= 1'b1;
        if (burst_cnt <= 1) begin
          burst_cnt <= $urandom_range(1, 16);
          gap_cnt <= ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_cnt <= burst_cnt - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  function automatic bit all_set_in(int n);
    for (int i = 0; i < n; i++) if (!in_ok[i]) return 0;
    return 1;
  endfunction

  function automatic bit all_set_grad(int n);
    for (int i = 0; i < n; i++) if (!grad_ok[i]) return 0;
    return 1;
  endfunction

  // queue a word; redirect any word that would read an unwritten input or gradient entry
  task automatic send(logic [2:0] op, int idx, logic [DataW-1:0] val);
    cmd_t c;
    if (op == OP_FWD && idx == gen_cols - 1 && !all_set_in(gen_cols - 1)) idx = gen_cols;
    if (op == OP_BWD && idx == gen_rows - 1 && !all_set_grad(gen_rows - 1)) idx = gen_rows;
    if (op == OP_OUTER && idx < gen_rows && !all_set_in(gen_cols)) idx = gen_rows;
    if (op == OP_FWD && idx < gen_cols) in_ok[idx] = 1;
    if (op == OP_BWD && idx < gen_rows) grad_ok[idx] = 1;
    c.op = op; c.idx = AddrW'(idx); c.val = val;
    cmd_q.push_back(c);
  endtask

  function automatic logic [DataW-1:0] rand_val();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return DataW'($urandom);
    endcase
  endfunction

  task automatic fwd_vector();
    for (int k = 0; k < gen_cols; k++) send(OP_FWD, k, rand_val());
  endtask

  task automatic bwd_vector();
    for (int r = 0; r < gen_rows; r++) send(OP_BWD, r, rand_val());
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (cmd_q.size() != 0 || start || result_q.size() != 0 || busy);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] ri, logic [DimW-1:0] d);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index_i <= ri;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready);
    if (ri == CFG_ROWS) rows_reg = d;
    else cols_reg = d;
    gen_rows = eff_dim(rows_reg, RowsMax);
    gen_cols = eff_dim(cols_reg, ColsMax);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: fwd_vector();
        3, 4:    bwd_vector();
        5, 6:    send(OP_OUTER, $urandom_range(0, gen_rows - 1), rand_val());
        7:       send(3'($urandom_range(0, 1)), $urandom_range(0, gen_rows * gen_cols - 1),
                      rand_val());
        default: send(3'($urandom_range(0, 7)), $urandom_range(0, 4095), DataW'($urandom));
      endcase
    end
  endtask

  initial begin
    logic [DimW-1:0] dr, dc;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // weights 0..15 cover every run up to 4 by 4
    for (int i = 0; i < 16; i++) send(OP_WRITE, i, rand_val());

    // field extremes, saturating adds, unused opcodes, out-of-range elements
    send(OP_WRITE, 4095, 16'h7fff);
    send(OP_WRITE, 0, 16'h8000);
    send(OP_WRITE, 5, 16'h7fff);
    send(OP_ADD, 5, 16'h7fff);
    send(OP_WRITE, 6, 16'h8000);
    send(OP_ADD, 6, 16'hffff);
    send(OP_ADD, 7, 16'h0001);
    send(3'd5, 4095, 16'hffff);
    send(3'd6, 0, 16'h0000);
    send(3'd7, 2730, 16'h5555);
    send(OP_FWD, 4095, 16'h1234);
    send(OP_BWD, 4095, 16'h1234);
    send(OP_OUTER, 4095, 16'h1234);
    drain();
    write_reg(CFG_ROWS, 7'd4);
    write_reg(CFG_COLS, 7'd4);
    for (int k = 0; k < 4; k++) send(OP_FWD, k, 16'h8000);
    bwd_vector();
    send(OP_OUTER, 3, 16'h8000);
    send(OP_OUTER, 4, 16'h7fff);
    drain();

    for (int p = 0; p < 4; p++) begin
      dr = DimW'($urandom_range(1, 4));
      dc = DimW'($urandom_range(1, 4));
      write_reg(CFG_ROWS, dr);
      write_reg(CFG_COLS, dc);
      random_phase(6);
      drain();
    end

    // dimensions past the array size and zero dimensions
    write_reg(CFG_ROWS, 7'd127);
    write_reg(CFG_COLS, 7'd0);
    send(OP_OUTER, 63, 16'h7fff);
    send(OP_OUTER, 64, 16'h7fff);
    send(OP_BWD, 5, 16'h1234);
    send(OP_FWD, 1, 16'h1234);
    send(OP_OUTER, 0, 16'h8000);
    drain();
    write_reg(CFG_ROWS, 7'd0);
    write_reg(CFG_COLS, 7'd127);
    send(OP_OUTER, 0, 16'h7fff);
    send(OP_FWD, 64, 16'h0001);
    send(OP_FWD, 5, 16'h0001);
    send(OP_BWD, 1, 16'h0001);
    drain();

    repeat (100) @(posedge clk_i);
    if (errors == 0 && result_q.size() == 0) begin
      $display("dense_layer_engine_core test passed");
    end else begin
      $display("dense_layer_engine_core test failed");
    end
    $finish;
  end

endmodule
